FILE: hw/rtl/curve_segment_index_builder_defines.svh
// ----------------------------------------------------------------------------
// Curve segment index builder assertion macros
// Shared property wrappers for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef CURVE_SEGMENT_INDEX_BUILDER_DEFINES_SVH
`define CURVE_SEGMENT_INDEX_BUILDER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CSIB_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("csib: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CSIB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("csib: next-cycle check failed");

`endif

FILE: hw/rtl/csib_pkg.sv
// ----------------------------------------------------------------------------
// Curve segment index builder package
// Payload types, register indexes and mode codes.
// ----------------------------------------------------------------------------
package csib_pkg;

  localparam int unsigned CNT_W      = 7;
  localparam int unsigned IDX_W      = 32;
  localparam int unsigned LIM_W      = 12;
  localparam int unsigned OFF_W      = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 12;

  localparam int unsigned CUBIC_TAPS  = 4;
  localparam int unsigned LINE_TAPS   = 2;
  localparam int unsigned BEZIER_STEP = 3;

  // opcode field
  localparam logic OP_CURVE    = 1'b0;
  localparam logic OP_REMAP_WR = 1'b1;

  // wrap_mode codes
  localparam logic [1:0] WRAP_OPEN      = 2'd0;
  localparam logic [1:0] WRAP_PERIODIC  = 2'd1;
  localparam logic [1:0] WRAP_SEGMENTED = 2'd2;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CUBIC_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WRAP_MODE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASIS_BEZIER = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REMAP_ENABLE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REMAP_LAST   = 3'd4;

  typedef struct packed {
    logic             opcode;
    logic [CNT_W-1:0] vertex_count;
    logic [LIM_W-1:0] remap_addr;
    logic [IDX_W-1:0] remap_value;
  } item_t;

  typedef struct packed {
    logic [IDX_W-1:0] index_a;
    logic [IDX_W-1:0] index_b;
    logic [IDX_W-1:0] index_c;
    logic [IDX_W-1:0] index_d;
    logic [IDX_W-1:0] curve_number;
    logic             last;
  } seg_t;

endpackage

FILE: hw/rtl/csib_stream_if.sv
// ----------------------------------------------------------------------------
// Curve segment index builder stream interface
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface csib_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

FILE: hw/rtl/csib_remap_mem.sv
// ----------------------------------------------------------------------------
// Remap table memory
// One write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module csib_remap_mem #(
  parameter int unsigned DEPTH = 4096
) (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [$clog2(DEPTH)-1:0]       waddr_i,
  input  logic [csib_pkg::IDX_W-1:0]     wdata_i,
  input  logic                           re_i,
  input  logic [$clog2(DEPTH)-1:0]       raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0]       raddr_b_i,
  output logic [csib_pkg::IDX_W-1:0]     rdata_a_o,
  output logic [csib_pkg::IDX_W-1:0]     rdata_b_o
);
  import csib_pkg::*;

  logic [IDX_W-1:0] mem_q [DEPTH];
  logic [IDX_W-1:0] rdata_a_q;
  logic [IDX_W-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

FILE: hw/rtl/curve_segment_index_builder.sv
// A curve transaction is taken in IDLE; its first segment goes through GEN and PUSH
//   to the output register, with RD_CD between them when remap is on (and CAP_CD
//   after RD_CD in cubic mode). Segments are built one at a time; the next tuple
//   starts only once PUSH hands the current one on (two remap reads per cycle
//   on the table's two read ports). Reset clears config, vertex base, curve number
//   and control; remap table contents stay undefined until written.
// ----------------------------------------------------------------------------
// Curve segment index builder
// Turns per-curve vertex counts into line or cubic segment index tuples,
// optionally remapped through a loaded vertex table.
// ----------------------------------------------------------------------------
module curve_segment_index_builder #(
  parameter int unsigned REMAP_DEPTH     = 4096,
  parameter int unsigned MAX_CURVE_VERTS = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  csib_stream_if.sink                       item_i,
  csib_stream_if.source                     seg_o,
  input  logic                              cfg_we_i,
  input  logic [csib_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [csib_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);
  import csib_pkg::*;

  localparam int unsigned AW = $clog2(REMAP_DEPTH);
  localparam logic [IDX_W-1:0] DEPTH_LAST = IDX_W'(REMAP_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_MAX    = CNT_W'(MAX_CURVE_VERTS);

  // Sequencer: IDLE takes transactions, GEN builds one raw tuple and starts
  // the a/b table reads, RD_CD captures a/b and starts c/d, CAP_CD captures
  // c/d, PUSH hands the tuple to the output register.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GEN,
    ST_RD_CD,
    ST_CAP_CD,
    ST_PUSH
  } state_e;

  // How the segments of the current curve are laid out.
  typedef enum logic [1:0] {
    KIND_CUBIC_PER,
    KIND_CUBIC_CLAMP,
    KIND_PAIRS,
    KIND_STRIP
  } kind_e;

  // Does a segment start at offset o of a curve with c vertices?
  function automatic logic seg_exists(kind_e k, logic [OFF_W-1:0] o,
                                      logic [OFF_W-1:0] c, logic [OFF_W-1:0] st);
    logic ok;
    case (k)
      KIND_CUBIC_PER:   ok = (o + st) <= c;
      // the first clamped window also exists when c + step > 4 (padded bezier)
      KIND_CUBIC_CLAMP: ok = ((o + OFF_W'(CUBIC_TAPS)) <= c) ||
                             ((o == '0) && ((c + st) > OFF_W'(CUBIC_TAPS)));
      KIND_PAIRS:       ok = o < c;
      KIND_STRIP:       ok = (o + OFF_W'(LINE_TAPS)) <= c;
      default:          ok = 1'b0;
    endcase
    return ok;
  endfunction

  function automatic logic [AW-1:0] clamp_addr(logic [IDX_W-1:0] idx,
                                               logic [IDX_W-1:0] lim);
    logic [IDX_W-1:0] t;
    t = (idx > lim) ? lim : idx;
    return t[AW-1:0];
  endfunction

  // config registers
  logic             cubic_q;
  logic [1:0]       wrap_q;
  logic             bezier_q;
  logic             remap_en_q;
  logic [LIM_W-1:0] remap_last_q;

  // running state
  logic [IDX_W-1:0] vbase_q;
  logic [IDX_W-1:0] curve_cnt_q;

  // per-curve / per-segment
  state_e           state_q;
  logic [CNT_W-1:0] cnt_q;
  logic [IDX_W-1:0] base_q;
  logic [IDX_W-1:0] cnum_q;
  logic [OFF_W-1:0] off_q;
  logic             closing_q;
  logic             go_close_q;
  logic             last_q;
  logic [IDX_W-1:0] tup_q [CUBIC_TAPS];

  // output register
  logic             out_valid_q;
  seg_t             out_q;

  // combinational
  kind_e            kind;
  logic [OFF_W-1:0] step;
  logic             item_fire;
  logic             curve_fire;
  logic [CNT_W-1:0] cnt_sat;
  logic             first_ok;
  logic             first_close;
  logic [IDX_W-1:0] vbase_inc;
  logic [OFF_W-1:0] cnt_ext;
  logic [OFF_W-1:0] tap_off [CUBIC_TAPS];
  logic [IDX_W-1:0] idx_d [CUBIC_TAPS];
  logic             nxt_ok;
  logic             goto_close;
  logic             seg_last;
  logic [IDX_W-1:0] lim;
  logic             mem_we;
  logic [IDX_W-1:0] waddr_ext;
  logic             mem_re;
  logic [AW-1:0]    raddr_a;
  logic [AW-1:0]    raddr_b;
  logic [IDX_W-1:0] rdata_a;
  logic [IDX_W-1:0] rdata_b;

  // --------------------------------------------------------------------------
  // Mode decode (config should only change while idle; the block does not enforce this)
  // --------------------------------------------------------------------------
  always_comb begin
    if (cubic_q) begin
      kind = (wrap_q == WRAP_PERIODIC) ? KIND_CUBIC_PER : KIND_CUBIC_CLAMP;
      step = bezier_q ? OFF_W'(BEZIER_STEP) : OFF_W'(1);
    end else if (wrap_q == WRAP_SEGMENTED) begin
      kind = KIND_PAIRS;
      step = OFF_W'(LINE_TAPS);
    end else begin
      kind = KIND_STRIP;
      step = OFF_W'(1);
    end
  end

  // --------------------------------------------------------------------------
  // Curve intake: saturate count, decide whether any segment comes out,
  // and how far the vertex base moves.
  // --------------------------------------------------------------------------
  assign item_fire  = item_i.valid && item_i.ready;
  assign curve_fire = item_fire && (item_i.payload.opcode == OP_CURVE);
  assign cnt_sat    = (item_i.payload.vertex_count > CNT_MAX) ? CNT_MAX
                                                              : item_i.payload.vertex_count;
  assign first_ok    = seg_exists(kind, '0, OFF_W'(cnt_sat), step);
  assign first_close = (kind == KIND_STRIP) && (wrap_q == WRAP_PERIODIC);

  always_comb begin
    case (kind)
      KIND_PAIRS: vbase_inc = IDX_W'(cnt_sat) + IDX_W'(cnt_sat[0]);  // round up to even
      KIND_STRIP: vbase_inc = (cnt_sat == '0) ? IDX_W'(1) : IDX_W'(cnt_sat);
      default:    vbase_inc = IDX_W'(cnt_sat);
    endcase
  end

  // --------------------------------------------------------------------------
  // Segment tuple generation
  // --------------------------------------------------------------------------
  assign cnt_ext = OFF_W'(cnt_q);

  always_comb begin
    logic [OFF_W-1:0] p;
    p = '0;
    for (int v = 0; v < CUBIC_TAPS; v++) begin
      tap_off[v] = '0;
    end
    case (kind)
      KIND_CUBIC_PER, KIND_CUBIC_CLAMP: begin
        for (int v = 0; v < CUBIC_TAPS; v++) begin
          p = off_q + OFF_W'(v);
          if (kind == KIND_CUBIC_PER) begin
            // p stays below count + 3, so three conditional subtracts wrap it
            for (int k = 0; k < CUBIC_TAPS - 1; k++) begin
              if (p >= cnt_ext) begin
                p = p - cnt_ext;
              end
            end
          end else if (p >= cnt_ext) begin
            p = cnt_ext - OFF_W'(1);  // clamp at the last vertex
          end
          tap_off[v] = p;
        end
      end
      default: begin
        if (closing_q) begin
          // closing segment: last vertex back to the first
          tap_off[0] = (cnt_ext == '0) ? '0 : cnt_ext - OFF_W'(1);
          tap_off[1] = '0;
        end else begin
          tap_off[0] = off_q;
          tap_off[1] = off_q + OFF_W'(1);
        end
      end
    endcase
  end

  always_comb begin
    for (int v = 0; v < CUBIC_TAPS; v++) begin
      if (cubic_q || (v < LINE_TAPS)) begin
        idx_d[v] = base_q + IDX_W'(tap_off[v]);
      end else begin
        idx_d[v] = '0;
      end
    end
  end

  assign nxt_ok     = seg_exists(kind, off_q + step, cnt_ext, step);
  assign goto_close = (kind == KIND_STRIP) && !closing_q && !nxt_ok &&
                      (wrap_q == WRAP_PERIODIC);
  assign seg_last   = closing_q || (!nxt_ok && !goto_close);

  // --------------------------------------------------------------------------
  // Remap table access. Writes happen only in idle, reads only while a curve
  // is being expanded, so accesses never overlap.
  // --------------------------------------------------------------------------
  assign lim = (IDX_W'(remap_last_q) > DEPTH_LAST) ? DEPTH_LAST : IDX_W'(remap_last_q);

  assign waddr_ext = IDX_W'(item_i.payload.remap_addr);
  assign mem_we    = item_fire && (item_i.payload.opcode == OP_REMAP_WR) &&
                     (waddr_ext < IDX_W'(REMAP_DEPTH));
  assign mem_re    = remap_en_q && ((state_q == ST_GEN) || (state_q == ST_RD_CD));
  assign raddr_a   = (state_q == ST_RD_CD) ? clamp_addr(tup_q[2], lim)
                                           : clamp_addr(idx_d[0], lim);
  assign raddr_b   = (state_q == ST_RD_CD) ? clamp_addr(tup_q[3], lim)
                                           : clamp_addr(idx_d[1], lim);

  csib_remap_mem #(
    .DEPTH (REMAP_DEPTH)
  ) u_remap_mem (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (waddr_ext[AW-1:0]),
    .wdata_i   (item_i.payload.remap_value),
    .re_i      (mem_re),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  // --------------------------------------------------------------------------
  // Sequencer, config and output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cubic_q      <= 1'b0;
      wrap_q       <= WRAP_OPEN;
      bezier_q     <= 1'b0;
      remap_en_q   <= 1'b0;
      remap_last_q <= '0;
      vbase_q      <= '0;
      curve_cnt_q  <= '0;
      state_q      <= ST_IDLE;
      off_q        <= '0;
      closing_q    <= 1'b0;
      go_close_q   <= 1'b0;
      last_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_CUBIC_MODE:   cubic_q      <= cfg_wdata_i[0];
          REG_WRAP_MODE:    wrap_q       <= cfg_wdata_i[1:0];
          REG_BASIS_BEZIER: bezier_q     <= cfg_wdata_i[0];
          REG_REMAP_ENABLE: remap_en_q   <= cfg_wdata_i[0];
          REG_REMAP_LAST:   remap_last_q <= cfg_wdata_i[LIM_W-1:0];
          default: ;
        endcase
      end

      // output valid: set when a tuple is loaded, cleared when it is taken
      if ((state_q == ST_PUSH) && (!out_valid_q || seg_o.ready)) begin
        out_valid_q <= 1'b1;
      end else if (seg_o.ready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (curve_fire) begin
            vbase_q     <= vbase_q + vbase_inc;
            curve_cnt_q <= curve_cnt_q + IDX_W'(1);
            off_q       <= '0;
            closing_q   <= !first_ok;
            if (first_ok || first_close) begin
              state_q <= ST_GEN;
            end
          end
        end
        ST_GEN: begin
          last_q     <= seg_last;
          go_close_q <= goto_close;
          state_q    <= remap_en_q ? ST_RD_CD : ST_PUSH;
        end
        ST_RD_CD: begin
          state_q <= cubic_q ? ST_CAP_CD : ST_PUSH;
        end
        ST_CAP_CD: begin
          state_q <= ST_PUSH;
        end
        ST_PUSH: begin
          if (!out_valid_q || seg_o.ready) begin
            out_q.index_a      <= tup_q[0];
            out_q.index_b      <= tup_q[1];
            out_q.index_c      <= tup_q[2];
            out_q.index_d      <= tup_q[3];
            out_q.curve_number <= cnum_q;
            out_q.last         <= last_q;
            if (last_q) begin
              state_q <= ST_IDLE;
            end else begin
              if (go_close_q) begin
                closing_q <= 1'b1;
              end else begin
                off_q <= off_q + step;
              end
              state_q <= ST_GEN;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath holding registers
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_IDLE) && curve_fire) begin
      cnt_q  <= cnt_sat;
      base_q <= vbase_q;
      cnum_q <= curve_cnt_q;
    end
    case (state_q)
      ST_GEN: begin
        for (int v = 0; v < CUBIC_TAPS; v++) begin
          tup_q[v] <= idx_d[v];
        end
      end
      ST_RD_CD: begin
        tup_q[0] <= rdata_a;
        tup_q[1] <= rdata_b;
      end
      ST_CAP_CD: begin
        tup_q[2] <= rdata_a;
        tup_q[3] <= rdata_b;
      end
      default: ;
    endcase
  end

  assign item_i.ready  = (state_q == ST_IDLE);
  assign seg_o.valid   = out_valid_q;
  assign seg_o.payload = out_q;

endmodule

FILE: hw/rtl/csib_checker.sv
// ----------------------------------------------------------------------------
// Curve segment index builder port checker
// Port-level properties, bound to the top level.
// ----------------------------------------------------------------------------
`include "curve_segment_index_builder_defines.svh"

module csib_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_i,
  input logic           out_valid_i,
  input logic           out_ready_i,
  input csib_pkg::seg_t out_seg_i
);
  import csib_pkg::*;

  // stalled output holds
  `CSIB_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
  `CSIB_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(out_seg_i))

  // a curve is still being expanded while a non-final segment waits
  `CSIB_ASSERT_SAME(a_no_take_mid_curve, clk_i, rst_ni, out_valid_i && !out_seg_i.last, !in_ready_i)

  // an accepted transaction never produces a segment in the very next cycle while the output was empty
  `CSIB_ASSERT_NEXT(a_no_instant_seg, clk_i, rst_ni, in_valid_i && in_ready_i && !out_valid_i, !out_valid_i)

endmodule

bind curve_segment_index_builder csib_checker u_csib_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (item_i.valid),
  .in_ready_i  (item_i.ready),
  .out_valid_i (seg_o.valid),
  .out_ready_i (seg_o.ready),
  .out_seg_i   (seg_o.payload)
);
